### rtl/acr_pkg.sv
// acr_pkg: shared types, sizes and codes for the audio capture ring writer.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps
package acr_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int MAX_FRAMES = 256;
    localparam int CHANNELS   = 2;

    localparam int KEPT_CHANNEL = (CHANNELS > 1) ? 1 : 0;
    localparam int WORD_CAP     = MAX_FRAMES * CHANNELS;

    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int WC_W    = $clog2(WORD_CAP + 1);
    localparam int RING_AW = SLOT_W + FRAME_W;
    localparam int QDEPTH  = 2;

    // input kinds
    localparam logic [1:0] KIND_CAPTURE = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FRAMES = 2'd0;
    localparam logic [1:0] REG_SLOTS  = 2'd1;
    localparam logic [1:0] REG_POLICY = 2'd2;

    // commit status codes
    localparam logic [1:0] ST_STORED       = 2'd0;
    localparam logic [1:0] ST_DROPPED_OLD  = 2'd1;
    localparam logic [1:0] ST_DROPPED_NEW  = 2'd2;

    // result kinds
    localparam logic RK_COMMIT = 1'b0;
    localparam logic RK_READ   = 1'b1;

    // back-end operations
    localparam logic [1:0] OP_STAGE   = 2'd0;
    localparam logic [1:0] OP_COMMIT  = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    typedef struct packed {
        logic [8:0] frames_per_slot;
        logic [4:0] slot_count;
        logic       overrun_policy;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         op;
        logic               stage_en;
        logic [FRAME_W-1:0] stage_addr;
        logic [31:0]        word;
        logic [8:0]         avail;
        logic [63:0]        stamp;
        logic [3:0]         rd_slot;
        logic [7:0]         rd_frame;
    } t_cmd;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  commit_status;
        logic [3:0]  slot_index;
        logic [8:0]  frame_count;
        logic [63:0] first_sample_index;
        logic [63:0] stamp_us;
        logic [31:0] read_data;
        logic [31:0] newest_drops;
        logic [31:0] oldest_drops;
    } t_result;

endpackage

### rtl/acr_front.sv
// acr_front: tracks the block word count and turns accepted words other
// than unkept capture words into back-end commands. Depends on acr_pkg.
`timescale 1ns / 1ps
module acr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_kind,
    input  logic [31:0]    i_sample_word,
    input  logic           i_block_last,
    input  logic [63:0]    i_time_us,
    input  logic [3:0]     i_read_slot,
    input  logic [7:0]     i_read_frame,
    input  acr_pkg::t_cfg  i_cfg,
    output logic           o_cmd_push,
    output acr_pkg::t_cmd  o_cmd
);
    import acr_pkg::*;

    logic [WC_W-1:0] r_wc;
    logic [WC_W-1:0] n_wc;
    logic [WC_W-1:0] wc_inc;
    logic [WC_W-1:0] frame_full;
    logic            keep;
    logic [8:0]      eff_frames;
    logic [8:0]      whole;

    always_comb begin
        if (i_cfg.frames_per_slot == 9'd0) begin
            eff_frames = 9'd1;
        end else if (i_cfg.frames_per_slot > 9'(MAX_FRAMES)) begin
            eff_frames = 9'(MAX_FRAMES);
        end else begin
            eff_frames = i_cfg.frames_per_slot;
        end
    end

    assign frame_full = WC_W'(r_wc / CHANNELS);
    assign keep   = (r_wc % CHANNELS == KEPT_CHANNEL) && (frame_full < WC_W'(MAX_FRAMES));
    assign wc_inc = (r_wc < WC_W'(WORD_CAP)) ? r_wc + WC_W'(1) : r_wc;
    assign whole  = 9'(wc_inc / CHANNELS);

    always_comb begin
        o_cmd            = '0;
        o_cmd.stage_en   = keep;
        o_cmd.stage_addr = frame_full[FRAME_W-1:0];
        o_cmd.word       = i_sample_word;
        o_cmd.avail      = (whole > eff_frames) ? eff_frames : whole;
        o_cmd.stamp      = i_time_us;
        o_cmd.rd_slot    = i_read_slot;
        o_cmd.rd_frame   = i_read_frame;
        o_cmd_push       = 1'b0;
        n_wc             = r_wc;
        o_cmd.op         = OP_STAGE;
        unique case (i_kind)
            KIND_CAPTURE: begin
                if (i_block_last) begin
                    o_cmd.op   = OP_COMMIT;
                    o_cmd_push = i_accept;
                    n_wc       = '0;
                end else begin
                    o_cmd_push = i_accept && keep;
                    n_wc       = wc_inc;
                end
            end
            KIND_READ: begin
                o_cmd.op   = OP_READ;
                o_cmd_push = i_accept;
            end
            KIND_RELEASE: begin
                o_cmd.op   = OP_RELEASE;
                o_cmd_push = i_accept;
            end
            default: o_cmd_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
        end else if (i_accept && i_kind == KIND_CAPTURE) begin
            r_wc <= n_wc;
        end
    end

endmodule

### rtl/acr_cmd_queue.sv
// acr_cmd_queue: short command queue between front and back.
// Depends on acr_pkg.
`timescale 1ns / 1ps
module acr_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acr_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output acr_pkg::t_cmd o_cmd
);
    import acr_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_cmd             r_mem [QDEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

endmodule

### rtl/acr_back.sv
// acr_back: executes commands: staging writes, block commit with overrun
// handling and row copy, consumer reads and releases. Depends on acr_pkg.
`timescale 1ns / 1ps
module acr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  acr_pkg::t_cfg    i_cfg,
    input  logic             i_cmd_valid,
    input  acr_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_res_valid,
    output acr_pkg::t_result o_res,
    input  logic             i_res_pop
);
    import acr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_COPY = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;

    logic [2:0]   r_state;
    logic [31:0]  r_head;
    logic [31:0]  r_tail;
    logic [63:0]  r_pos;
    logic [31:0]  r_newest;
    logic [31:0]  r_oldest;
    logic [8:0]   r_frames [MAX_SLOTS];
    logic [63:0]  r_first  [MAX_SLOTS];
    logic [63:0]  r_stamp  [MAX_SLOTS];

    logic [31:0]  r_ring [MAX_SLOTS*MAX_FRAMES];
    logic [31:0]  r_stg  [MAX_FRAMES];
    logic [31:0]  r_ring_q;
    logic [31:0]  r_stg_q;

    logic [4:0]   r_bit;
    logic [4:0]   r_rem;
    logic [8:0]   r_len;
    logic [8:0]   r_idx;
    logic [63:0]  r_cstamp;
    logic [3:0]   r_rslot;
    logic [7:0]   r_rframe;

    logic         r_res_valid;
    t_result      r_res;

    logic [4:0]   eff_slots;
    logic         out_free;
    logic [4:0]   rem_sh;
    logic [SLOT_W-1:0] cslot;
    logic         full;
    logic         drop_new;
    logic         drop_old;

    logic               stg_we;
    logic [FRAME_W-1:0] stg_wa;
    logic               stg_re;
    logic               ring_we;
    logic               ring_re;
    logic [RING_AW-1:0] ring_wa;
    logic [RING_AW-1:0] ring_ra;

    always_comb begin
        if (i_cfg.slot_count == 5'd0) begin
            eff_slots = 5'd1;
        end else if (i_cfg.slot_count > 5'(MAX_SLOTS)) begin
            eff_slots = 5'(MAX_SLOTS);
        end else begin
            eff_slots = i_cfg.slot_count;
        end
    end

    assign out_free = !r_res_valid || i_res_pop;
    assign rem_sh   = {r_rem[3:0], r_head[r_bit]};
    assign cslot    = r_rem[SLOT_W-1:0];
    assign full     = (r_head + 32'd1 - r_tail) > {27'd0, eff_slots};
    assign drop_new = full && !i_cfg.overrun_policy;
    assign drop_old = full && i_cfg.overrun_policy;

    always_comb begin
        o_cmd_pop = 1'b0;
        if (r_state == S_IDLE && i_cmd_valid) begin
            unique case (i_cmd.op) inside
                OP_STAGE, OP_RELEASE: o_cmd_pop = 1'b1;
                OP_COMMIT, OP_READ:   o_cmd_pop = out_free;
                default:              o_cmd_pop = 1'b0;
            endcase
        end
    end

    assign stg_we  = o_cmd_pop && i_cmd.stage_en
                     && (i_cmd.op == OP_STAGE || i_cmd.op == OP_COMMIT);
    assign stg_wa  = i_cmd.stage_addr;
    assign stg_re  = (r_state == S_COPY) && (r_idx < r_len);
    assign ring_we = (r_state == S_COPY) && (r_idx != 9'd0);
    assign ring_wa = {cslot, FRAME_W'(r_idx - 9'd1)};
    assign ring_re = o_cmd_pop && (i_cmd.op == OP_READ);
    assign ring_ra = {i_cmd.rd_slot, i_cmd.rd_frame};

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            r_stg[stg_wa] <= i_cmd.word;
        end
        if (stg_re) begin
            r_stg_q <= r_stg[r_idx[FRAME_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wa] <= r_stg_q;
        end
        if (ring_re) begin
            r_ring_q <= r_ring[ring_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_pos       <= '0;
            r_newest    <= '0;
            r_oldest    <= '0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_frames[i] <= '0;
                r_first[i]  <= '0;
                r_stamp[i]  <= '0;
            end
        end else begin
            if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        case (i_cmd.op)
                            OP_RELEASE: begin
                                if (r_head != r_tail) begin
                                    r_tail <= r_tail + 32'd1;
                                end
                            end
                            OP_READ: begin
                                r_rslot  <= i_cmd.rd_slot;
                                r_rframe <= i_cmd.rd_frame;
                                r_state  <= S_RD;
                            end
                            OP_COMMIT: begin
                                r_len    <= i_cmd.avail;
                                r_cstamp <= i_cmd.stamp;
                                r_rem    <= '0;
                                r_bit    <= 5'd31;
                                r_state  <= S_MOD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MOD: begin
                    // one bit of head mod slot count per cycle
                    r_rem <= (rem_sh >= eff_slots) ? rem_sh - eff_slots : rem_sh;
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_res_valid             <= 1'b1;
                    r_res.result_kind       <= RK_COMMIT;
                    r_res.slot_index        <= 4'(cslot);
                    r_res.frame_count       <= r_len;
                    r_res.first_sample_index <= r_pos;
                    r_res.stamp_us          <= r_cstamp;
                    r_res.read_data         <= '0;
                    r_res.newest_drops      <= drop_new ? r_newest + 32'd1 : r_newest;
                    r_res.oldest_drops      <= drop_old ? r_oldest + 32'd1 : r_oldest;
                    r_pos                   <= r_pos + {55'd0, r_len};
                    if (drop_new) begin
                        r_res.commit_status <= ST_DROPPED_NEW;
                        r_newest            <= r_newest + 32'd1;
                        r_state             <= S_IDLE;
                    end else begin
                        r_res.commit_status <= full ? ST_DROPPED_OLD : ST_STORED;
                        if (full) begin
                            r_tail   <= r_tail + 32'd1;
                            r_oldest <= r_oldest + 32'd1;
                        end
                        r_frames[cslot] <= r_len;
                        r_first[cslot]  <= r_pos;
                        r_stamp[cslot]  <= r_cstamp;
                        r_head          <= r_head + 32'd1;
                        r_idx           <= '0;
                        r_state         <= (r_len == 9'd0) ? S_IDLE : S_COPY;
                    end
                end
                S_COPY: begin
                    // read staging at idx, write ring at idx-1
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == r_len) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_res_valid              <= 1'b1;
                    r_res.result_kind        <= RK_READ;
                    r_res.commit_status      <= ST_STORED;
                    r_res.slot_index         <= r_rslot;
                    r_res.frame_count        <= r_frames[r_rslot];
                    r_res.first_sample_index <= r_first[r_rslot];
                    r_res.stamp_us           <= r_stamp[r_rslot];
                    r_res.read_data          <= ({1'b0, r_rframe} < r_frames[r_rslot])
                                                ? r_ring_q : 32'd0;
                    r_res.newest_drops       <= r_newest;
                    r_res.oldest_drops       <= r_oldest;
                    r_state                  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COPY |-> r_idx <= r_len)
        else $error("copy index ran past block length");

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC || r_state == S_RD) |-> !r_res_valid)
        else $error("result register overwritten while waiting");

    a_tail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_tail != $past(r_tail)) |-> r_tail == $past(r_tail) + 32'd1)
        else $error("tail moved by more than one");

    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_head != $past(r_head)) |-> $past(r_state) == S_DEC)
        else $error("head moved outside a commit");

endmodule

### rtl/audio_capture_ring_writer.sv
// audio_capture_ring_writer: top level; config registers, front, command
// queue and back. Depends on acr_pkg, acr_front, acr_cmd_queue, acr_back.
`timescale 1ns / 1ps
// Usage:
//  Input channel is a queue push side: a word is taken when push=1 and
//  full=0. kind selects capture word, consumer read or slot release.
//  Capture words of the kept channel go to a staging row; the word with
//  block_last commits the row to the ring slot at head mod slot_count.
//  Result channel is a queue pop side: while empty=0 the oldest result is
//  on the o_ ports; it is taken when pop=1. One result per commit or read.
//  Path from the accepting edge: a read result passes the queue and the
//  registered ring read; a commit report passes the queue hop, the serial
//  head mod slot count and a decision state, then a stored block copies
//  its row into the ring. Throughput: staging and release words drain at
//  one per cycle while the back end is idle; a commit holds it through
//  its mod, decision and copy states, a read through its read state.
//  Items behind it wait in the two-entry command queue; full rises when
//  both entries are taken. A waiting result (pop low) holds the next
//  commit or read at the queue head, so later words pile up behind it
//  until full rises. Reset (synchronous, active low) clears counters,
//  slot tables, queues and restores registers to 256 frames, 16 slots,
//  drop-oldest policy. Config is written through cfg_we/cfg_idx/cfg_data
//  by the user only while idle; the block does not enforce this.
module audio_capture_ring_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_sample_word,
    input  logic        i_block_last,
    input  logic [63:0] i_time_us,
    input  logic [3:0]  i_read_slot,
    input  logic [7:0]  i_read_frame,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [1:0]  o_commit_status,
    output logic [3:0]  o_slot_index,
    output logic [8:0]  o_frame_count,
    output logic [63:0] o_first_sample_index,
    output logic [63:0] o_stamp_us,
    output logic [31:0] o_read_data,
    output logic [31:0] o_newest_drops,
    output logic [31:0] o_oldest_drops,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);
    import acr_pkg::*;

    t_cfg    r_cfg;
    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_result res;
    logic    accept;
    logic    cmd_push;
    logic    q_valid;
    logic    q_pop;
    logic    res_valid;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frames_per_slot <= 9'd256;
            r_cfg.slot_count      <= 5'd16;
            r_cfg.overrun_policy  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAMES: r_cfg.frames_per_slot <= i_cfg_data;
                REG_SLOTS:  r_cfg.slot_count      <= i_cfg_data[4:0];
                REG_POLICY: r_cfg.overrun_policy  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign accept = push && !full;

    acr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_sample_word (i_sample_word),
        .i_block_last  (i_block_last),
        .i_time_us     (i_time_us),
        .i_read_slot   (i_read_slot),
        .i_read_frame  (i_read_frame),
        .i_cfg         (r_cfg),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd)
    );

    // full is the queue's full flag: the front never holds a word itself
    acr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    acr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop && res_valid)
    );

    assign empty                = !res_valid;
    assign o_result_kind        = res.result_kind;
    assign o_commit_status      = res.commit_status;
    assign o_slot_index         = res.slot_index;
    assign o_frame_count        = res.frame_count;
    assign o_first_sample_index = res.first_sample_index;
    assign o_stamp_us           = res.stamp_us;
    assign o_read_data          = res.read_data;
    assign o_newest_drops       = res.newest_drops;
    assign o_oldest_drops       = res.oldest_drops;

endmodule
